/* design/rcpa_pkg.sv */
// Shared types and constants for the reference-counted page allocator.
// No dependencies; imported by rcpa_csr, the allocator core and the testbench.
`default_nettype none

package rcpa_pkg;

   localparam int NUM_PAGES  = 65536;
   localparam int PAGE_BITS  = $clog2(NUM_PAGES);
   localparam int DEPTH_BITS = PAGE_BITS + 1;
   localparam int COUNT_BITS = 16;

   localparam logic [COUNT_BITS-1:0] COUNT_MAX  = '1;
   localparam logic [DEPTH_BITS-1:0] STACK_FULL = DEPTH_BITS'(NUM_PAGES);
   localparam logic [PAGE_BITS-1:0]  LAST_PAGE  = PAGE_BITS'(NUM_PAGES - 1);

   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;

   typedef enum logic {
      REG_FIRST_PAGE      = 1'b0,
      REG_REFCOUNT_ENABLE = 1'b1
   } reg_index_type;

   typedef enum logic [1:0] {
      CMD_ALLOC = 2'd0,
      CMD_FREE  = 2'd1,
      CMD_INCR  = 2'd2,
      CMD_READ  = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_NO_PAGE   = 3'd1,
      ST_RANGE     = 3'd2,
      ST_ZERO      = 3'd3,
      ST_SATURATED = 3'd4
   } status_type;

   typedef struct packed {
      logic [PAGE_BITS-1:0] first_page;
      logic                 refcount_enable;
   } cfg_type;

endpackage

`default_nettype wire

/* design/rcpa_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies; used for the free-page stack and the reference count table.
`default_nettype none

module rcpa_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 65536
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* design/rcpa_csr.sv */
// APB configuration registers of the page allocator: first_page and refcount_enable.
// Depends on rcpa_pkg for the register indexes and the configuration struct.
`default_nettype none

module rcpa_csr (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 csr_psel,
   input  wire logic                                 csr_penable,
   input  wire logic                                 csr_pwrite,
   input  wire logic [rcpa_pkg::CSR_ADDR_BITS-1:0]   csr_paddr,
   input  wire logic [rcpa_pkg::CSR_DATA_BITS-1:0]   csr_pwdata,
   output logic      [rcpa_pkg::CSR_DATA_BITS-1:0]   csr_prdata,
   output logic                                      csr_pready,
   output rcpa_pkg::cfg_type                         cfg
);

   import rcpa_pkg::*;

   logic [PAGE_BITS-1:0] first_page_ff;
   logic                 enable_ff;
   logic                 write_en;
   reg_index_type        reg_index;

   // registers sit at byte offsets 0 and 4; bit 2 selects
   assign reg_index  = reg_index_type'(csr_paddr[2]);
   assign csr_pready = 1'b1;
   assign write_en   = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         first_page_ff <= '0;
         enable_ff     <= 1'b0;
      end else if (write_en) begin
         unique case (reg_index)
            REG_FIRST_PAGE:      first_page_ff <= csr_pwdata[PAGE_BITS-1:0];
            REG_REFCOUNT_ENABLE: enable_ff     <= csr_pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_index)
         REG_FIRST_PAGE:      csr_prdata = CSR_DATA_BITS'(first_page_ff);
         REG_REFCOUNT_ENABLE: csr_prdata = CSR_DATA_BITS'(enable_ff);
         default:             csr_prdata = '0;
      endcase
   end

   assign cfg.first_page      = first_page_ff;
   assign cfg.refcount_enable = enable_ff;

endmodule

`default_nettype wire

/* design/refcounted_page_allocator_core.sv */
// Page allocator core: LIFO free-page stack and reference count table in two RAMs.
// Flow: an allocate that pops a page goes S_IDLE, S_POP, S_UPDATE (stack read, then count
// read at the popped page); other commands go S_IDLE, S_UPDATE; the result is registered
// from S_UPDATE. busy stays high until the result shows, so commands never overlap.
// Reset: a clear pass zeroes every count table entry, busy high meanwhile; CSR writes
// are taken throughout. Results are a one-cycle strobe; the receiver cannot stall.
`default_nettype none

module refcounted_page_allocator_core (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 start,
   output logic                                      busy,
   input  wire logic [1:0]                           req_command,
   input  wire logic [rcpa_pkg::PAGE_BITS-1:0]       req_page_number,
   output logic                                      rsp_valid,
   output logic      [2:0]                           rsp_status,
   output logic      [rcpa_pkg::PAGE_BITS-1:0]       rsp_granted_page,
   output logic      [rcpa_pkg::COUNT_BITS-1:0]      rsp_reference_count,
   output logic                                      rsp_returned_to_pool,
   output logic      [rcpa_pkg::DEPTH_BITS-1:0]      rsp_free_pages,
   input  wire logic                                 csr_psel,
   input  wire logic                                 csr_penable,
   input  wire logic                                 csr_pwrite,
   input  wire logic [rcpa_pkg::CSR_ADDR_BITS-1:0]   csr_paddr,
   input  wire logic [rcpa_pkg::CSR_DATA_BITS-1:0]   csr_pwdata,
   output logic      [rcpa_pkg::CSR_DATA_BITS-1:0]   csr_prdata,
   output logic                                      csr_pready
);

   import rcpa_pkg::*;

   typedef enum logic [1:0] {
      S_CLEAR,
      S_IDLE,
      S_POP,
      S_UPDATE
   } state_type;

   cfg_type cfg;

   state_type             state_ff,       state_in;
   logic [PAGE_BITS-1:0]  clear_addr_ff,  clear_addr_in;
   logic [DEPTH_BITS-1:0] depth_ff,       depth_in;
   cmd_type               cmd_ff,         cmd_in;
   logic [PAGE_BITS-1:0]  page_ff,        page_in;
   logic [PAGE_BITS-1:0]  granted_ff,     granted_in;
   logic                  pop_ok_ff,      pop_ok_in;
   logic                  valid_ff,       valid_in;
   status_type            status_ff,      status_in;
   logic [PAGE_BITS-1:0]  rsp_granted_ff, rsp_granted_in;
   logic [COUNT_BITS-1:0] count_ff,       count_in;
   logic                  pushed_ff,      pushed_in;

   logic                  stack_we;
   logic [PAGE_BITS-1:0]  stack_waddr;
   logic [PAGE_BITS-1:0]  stack_raddr;
   logic [PAGE_BITS-1:0]  stack_rdata;
   logic                  ref_we;
   logic [PAGE_BITS-1:0]  ref_waddr;
   logic [COUNT_BITS-1:0] ref_wdata;
   logic [PAGE_BITS-1:0]  ref_raddr;
   logic [COUNT_BITS-1:0] ref_rdata;
   logic [DEPTH_BITS-1:0] depth_dec;
   logic                  stack_full;

   rcpa_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   rcpa_ram #(.WIDTH(PAGE_BITS), .DEPTH(NUM_PAGES)) u_stack_ram (
      .clock   (clock),
      .wr_en   (stack_we),
      .wr_addr (stack_waddr),
      .wr_data (page_ff),
      .rd_addr (stack_raddr),
      .rd_data (stack_rdata)
   );

   rcpa_ram #(.WIDTH(COUNT_BITS), .DEPTH(NUM_PAGES)) u_ref_ram (
      .clock   (clock),
      .wr_en   (ref_we),
      .wr_addr (ref_waddr),
      .wr_data (ref_wdata),
      .rd_addr (ref_raddr),
      .rd_data (ref_rdata)
   );

   assign depth_dec   = depth_ff - DEPTH_BITS'(1);
   assign stack_full  = (depth_ff == STACK_FULL);
   assign stack_raddr = depth_dec[PAGE_BITS-1:0];
   assign stack_waddr = depth_ff[PAGE_BITS-1:0];
   // popped page comes straight from the stack RAM output while in S_POP
   assign ref_raddr   = (state_ff == S_POP) ? stack_rdata : req_page_number;
   assign busy        = (state_ff != S_IDLE);

   always_comb begin
      state_in       = state_ff;
      clear_addr_in  = clear_addr_ff;
      depth_in       = depth_ff;
      cmd_in         = cmd_ff;
      page_in        = page_ff;
      granted_in     = granted_ff;
      pop_ok_in      = pop_ok_ff;
      valid_in       = 1'b0;
      status_in      = status_ff;
      rsp_granted_in = rsp_granted_ff;
      count_in       = count_ff;
      pushed_in      = pushed_ff;
      stack_we       = 1'b0;
      ref_we         = 1'b0;
      ref_waddr      = page_ff;
      ref_wdata      = '0;

      unique case (state_ff)
         S_CLEAR: begin
            ref_we        = 1'b1;
            ref_waddr     = clear_addr_ff;
            clear_addr_in = clear_addr_ff + PAGE_BITS'(1);
            if (clear_addr_ff == LAST_PAGE) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (start) begin
               cmd_in    = cmd_type'(req_command);
               page_in   = req_page_number;
               pop_ok_in = 1'b0;
               if (cmd_type'(req_command) == CMD_ALLOC && depth_ff != '0) begin
                  state_in = S_POP;
               end else begin
                  state_in = S_UPDATE;
               end
            end
         end
         S_POP: begin
            depth_in   = depth_dec;
            granted_in = stack_rdata;
            pop_ok_in  = 1'b1;
            state_in   = S_UPDATE;
         end
         S_UPDATE: begin
            valid_in       = 1'b1;
            state_in       = S_IDLE;
            status_in      = ST_OK;
            rsp_granted_in = '0;
            count_in       = '0;
            pushed_in      = 1'b0;
            case (cmd_ff)
               CMD_ALLOC: begin
                  if (!pop_ok_ff) begin
                     status_in = ST_NO_PAGE;
                  end else begin
                     rsp_granted_in = granted_ff;
                     ref_waddr      = granted_ff;
                     if (cfg.refcount_enable) begin
                        ref_we    = 1'b1;
                        ref_wdata = COUNT_BITS'(1);
                        count_in  = COUNT_BITS'(1);
                     end else begin
                        count_in = ref_rdata;
                     end
                  end
               end
               CMD_FREE: begin
                  if (page_ff < cfg.first_page) begin
                     status_in = ST_RANGE;
                  end else if (cfg.refcount_enable) begin
                     if (ref_rdata == '0) begin
                        status_in = ST_ZERO;
                     end else begin
                        ref_we    = 1'b1;
                        ref_wdata = ref_rdata - COUNT_BITS'(1);
                        count_in  = ref_rdata - COUNT_BITS'(1);
                        // last reference gone: return the page unless the stack is full
                        if (ref_rdata == COUNT_BITS'(1) && !stack_full) begin
                           stack_we  = 1'b1;
                           pushed_in = 1'b1;
                           depth_in  = depth_ff + DEPTH_BITS'(1);
                        end
                     end
                  end else begin
                     count_in = ref_rdata;
                     if (!stack_full) begin
                        stack_we  = 1'b1;
                        pushed_in = 1'b1;
                        depth_in  = depth_ff + DEPTH_BITS'(1);
                     end
                  end
               end
               CMD_INCR: begin
                  if (ref_rdata == COUNT_MAX) begin
                     status_in = ST_SATURATED;
                     count_in  = ref_rdata;
                  end else begin
                     ref_we    = 1'b1;
                     ref_wdata = ref_rdata + COUNT_BITS'(1);
                     count_in  = ref_rdata + COUNT_BITS'(1);
                  end
               end
               default: begin
                  count_in = ref_rdata;
               end
            endcase
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         clear_addr_ff <= '0;
         depth_ff      <= '0;
         valid_ff      <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clear_addr_ff <= clear_addr_in;
         depth_ff      <= depth_in;
         valid_ff      <= valid_in;
      end
      cmd_ff         <= cmd_in;
      page_ff        <= page_in;
      granted_ff     <= granted_in;
      pop_ok_ff      <= pop_ok_in;
      status_ff      <= status_in;
      rsp_granted_ff <= rsp_granted_in;
      count_ff       <= count_in;
      pushed_ff      <= pushed_in;
   end

   assign rsp_valid            = valid_ff;
   assign rsp_status           = status_ff;
   assign rsp_granted_page     = rsp_granted_ff;
   assign rsp_reference_count  = count_ff;
   assign rsp_returned_to_pool = pushed_ff;
   // depth register already reflects the last command while the strobe is up
   assign rsp_free_pages       = depth_ff;

endmodule

`default_nettype wire

/* dv/refcounted_page_allocator_core_tb.sv */
// Self-checking testbench for refcounted_page_allocator_core: free-stack and count-table
// predictor, command driver, result monitor and APB register access.
// Depends on rcpa_pkg and the allocator core RTL.
module refcounted_page_allocator_core_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import rcpa_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 2_000_000;

   typedef struct {
      cmd_type              command;
      logic [PAGE_BITS-1:0] page;
   } page_request_type;

   typedef struct packed {
      status_type            status;
      logic [PAGE_BITS-1:0]  granted;
      logic [COUNT_BITS-1:0] count;
      logic                  pushed;
      logic [DEPTH_BITS-1:0] depth;
   } page_result_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     start = 1'b0;
   logic                     busy;
   logic [1:0]               req_command = CMD_READ;
   logic [PAGE_BITS-1:0]     req_page_number = '0;
   logic                     rsp_valid;
   logic [2:0]               rsp_status;
   logic [PAGE_BITS-1:0]     rsp_granted_page;
   logic [COUNT_BITS-1:0]    rsp_reference_count;
   logic                     rsp_returned_to_pool;
   logic [DEPTH_BITS-1:0]    rsp_free_pages;
   logic                     csr_psel = 1'b0;
   logic                     csr_penable = 1'b0;
   logic                     csr_pwrite = 1'b0;
   logic [CSR_ADDR_BITS-1:0] csr_paddr = '0;
   logic [CSR_DATA_BITS-1:0] csr_pwdata = '0;
   logic [CSR_DATA_BITS-1:0] csr_prdata;
   logic                     csr_pready;

   // predicted allocator state
   bit [COUNT_BITS-1:0] page_refs [NUM_PAGES];
   bit [PAGE_BITS-1:0]  free_list [NUM_PAGES];
   int unsigned         free_depth = 0;
   logic [PAGE_BITS-1:0] cfg_first_page = '0;
   logic                 cfg_count_on = 1'b0;

   page_request_type commands_to_send [$];
   page_result_type  results_due [$];
   int unsigned   queued_total = 0;
   int unsigned   sent_total = 0;
   int unsigned   checked_total = 0;
   int unsigned   mismatches = 0;
   int unsigned   cycle_count = 0;
   int unsigned   idle_pct = 26;

   refcounted_page_allocator_core dut (
      .clock                (clock),
      .reset                (reset),
      .start                (start),
      .busy                 (busy),
      .req_command          (req_command),
      .req_page_number      (req_page_number),
      .rsp_valid            (rsp_valid),
      .rsp_status           (rsp_status),
      .rsp_granted_page     (rsp_granted_page),
      .rsp_reference_count  (rsp_reference_count),
      .rsp_returned_to_pool (rsp_returned_to_pool),
      .rsp_free_pages       (rsp_free_pages),
      .csr_psel             (csr_psel),
      .csr_penable          (csr_penable),
      .csr_pwrite           (csr_pwrite),
      .csr_paddr            (csr_paddr),
      .csr_pwdata           (csr_pwdata),
      .csr_prdata           (csr_prdata),
      .csr_pready           (csr_pready)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic logic push_free(logic [PAGE_BITS-1:0] page);
      if (free_depth >= NUM_PAGES) return 1'b0;
      free_list[free_depth] = page;
      free_depth++;
      return 1'b1;
   endfunction

   // Update the predicted stack and counts for one request and return its result.
   function automatic page_result_type apply_page_command(cmd_type cmd,
                                                          logic [PAGE_BITS-1:0] page);
      page_result_type       r;
      logic [COUNT_BITS-1:0] held;
      r = '0;
      r.status = ST_OK;
      case (cmd)
         CMD_ALLOC: begin
            if (free_depth == 0) begin
               r.status = ST_NO_PAGE;
            end else begin
               free_depth--;
               r.granted = free_list[free_depth];
               if (int'(r.granted) < NUM_PAGES) begin
                  if (cfg_count_on) page_refs[r.granted] = COUNT_BITS'(1);
                  r.count = page_refs[r.granted];
               end
            end
         end
         CMD_FREE: begin
            if (page < cfg_first_page || int'(page) >= NUM_PAGES) begin
               r.status = ST_RANGE;
            end else if (cfg_count_on) begin
               held = page_refs[page];
               if (held == 0) begin
                  r.status = ST_ZERO;
               end else begin
                  page_refs[page] = held - 1'b1;
                  r.count = held - 1'b1;
                  if (held == 1) r.pushed = push_free(page);
               end
            end else begin
               // counting off: push regardless of the count, duplicates allowed
               r.count = page_refs[page];
               r.pushed = push_free(page);
            end
         end
         CMD_INCR: begin
            if (int'(page) >= NUM_PAGES) begin
               r.status = ST_RANGE;
            end else if (page_refs[page] == COUNT_MAX) begin
               r.status = ST_SATURATED;
               r.count = page_refs[page];
            end else begin
               page_refs[page] = page_refs[page] + 1'b1;
               r.count = page_refs[page];
            end
         end
         default: begin
            if (int'(page) >= NUM_PAGES) r.status = ST_RANGE;
            else r.count = page_refs[page];
         end
      endcase
      r.depth = free_depth[DEPTH_BITS-1:0];
      return r;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] want, logic [31:0] got);
      mismatches++;
      $display("%0t: %s mismatch: expected 0x%0h, got 0x%0h", $time, what, want, got);
   endtask

   // Request driver: present the next queued command, hold it until taken.
   always @(posedge clock) begin : drive_requests
      page_request_type next_req;
      logic             taken;
      taken = start && !busy;
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (taken) begin
            results_due.push_back(apply_page_command(cmd_type'(req_command), req_page_number));
            sent_total++;
         end
         if (!start || taken) begin
            if (commands_to_send.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
               next_req = commands_to_send.pop_front();
               start <= 1'b1;
               req_command <= next_req.command;
               req_page_number <= next_req.page;
            end else begin
               // idle: scramble the fields, they must be ignored
               start <= 1'b0;
               req_command <= 2'($urandom);
               req_page_number <= PAGE_BITS'($urandom);
            end
         end
      end
   end

   always @(posedge clock) begin : check_results
      page_result_type want;
      if (!reset && rsp_valid) begin
         if (results_due.size() == 0) begin
            report_mismatch("unexpected result, status", '0, 32'(rsp_status));
         end else begin
            want = results_due.pop_front();
            checked_total++;
            if (rsp_status !== want.status)
               report_mismatch("status", 32'(want.status), 32'(rsp_status));
            if (rsp_granted_page !== want.granted)
               report_mismatch("granted_page", 32'(want.granted), 32'(rsp_granted_page));
            if (rsp_reference_count !== want.count)
               report_mismatch("reference_count", 32'(want.count), 32'(rsp_reference_count));
            if (rsp_returned_to_pool !== want.pushed)
               report_mismatch("returned_to_pool", 32'(want.pushed),
                               32'(rsp_returned_to_pool));
            if (rsp_free_pages !== want.depth)
               report_mismatch("free_pages", 32'(want.depth), 32'(rsp_free_pages));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d results outstanding", $time,
                  queued_total - checked_total);
         $display("[refcounted_page_allocator_core] ERROR");
         $finish;
      end
   end

   task automatic queue_command(cmd_type cmd, logic [PAGE_BITS-1:0] page);
      page_request_type item;
      item.command = cmd;
      item.page = page;
      commands_to_send.push_back(item);
      queued_total++;
   endtask

   // Hold until every queued request has its result and the core is idle.
   task automatic wait_for_quiet();
      while (checked_total < queued_total) @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic csr_access(reg_index_type idx, logic write_en, logic [31:0] value);
      logic [CSR_DATA_BITS-1:0] want;
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= write_en;
      csr_paddr <= CSR_ADDR_BITS'(int'(idx) * 4);
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      if (write_en) begin
         if (idx == REG_FIRST_PAGE) cfg_first_page = value[PAGE_BITS-1:0];
         else cfg_count_on = value[0];
      end else begin
         want = (idx == REG_FIRST_PAGE) ? CSR_DATA_BITS'(cfg_first_page)
                                        : CSR_DATA_BITS'(cfg_count_on);
         if (csr_prdata !== want) report_mismatch("register readback", want, csr_prdata);
      end
   endtask

   // Write both registers with junk in the unused upper bits, then read them back.
   task automatic set_config(logic [PAGE_BITS-1:0] first, logic enable);
      csr_access(REG_FIRST_PAGE, 1'b1, {16'($urandom), first});
      csr_access(REG_REFCOUNT_ENABLE, 1'b1, {31'($urandom), enable});
      csr_access(REG_FIRST_PAGE, 1'b0, '0);
      csr_access(REG_REFCOUNT_ENABLE, 1'b0, '0);
   endtask

   // Mostly traffic on a small set of live pages, with page lifetimes
   // (take a reference, read, drop it twice) mixed with noise and corner pages.
   task automatic queue_random_mix(int unsigned n_items);
      logic [PAGE_BITS-1:0] hot [8];
      logic [PAGE_BITS-1:0] page;
      int unsigned          h;
      int unsigned          made;
      int unsigned          pick;
      cmd_type              cmd;
      foreach (hot[i]) begin
         h = int'(cfg_first_page) + $urandom_range(0, 63);
         hot[i] = (h > LAST_PAGE) ? LAST_PAGE : h[PAGE_BITS-1:0];
      end
      made = 0;
      while (made < n_items) begin
         pick = $urandom_range(0, 99);
         if (pick < 15) begin
            page = hot[$urandom_range(0, 7)];
            queue_command(CMD_INCR, page);
            queue_command(CMD_READ, page);
            queue_command(CMD_FREE, page);
            queue_command(CMD_FREE, page);
            made += 4;
         end else begin
            pick = $urandom_range(0, 99);
            cmd = (pick < 25) ? CMD_ALLOC : (pick < 55) ? CMD_FREE :
                  (pick < 85) ? CMD_INCR : CMD_READ;
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
               page = hot[$urandom_range(0, 7)];
            end else if (pick < 90) begin
               page = PAGE_BITS'($urandom);
            end else begin
               case ($urandom_range(0, 3))
                  0: page = '0;
                  1: page = LAST_PAGE;
                  2: page = cfg_first_page;
                  default: page = cfg_first_page - 1'b1;
               endcase
            end
            queue_command(cmd, page);
            made++;
         end
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      wait_for_quiet();

      // directed: counting off, whole range freeable
      queue_command(CMD_ALLOC, '0);
      queue_command(CMD_READ, '0);
      queue_command(CMD_READ, LAST_PAGE);
      queue_command(CMD_FREE, '0);
      queue_command(CMD_FREE, LAST_PAGE);
      queue_command(CMD_INCR, LAST_PAGE);
      queue_command(CMD_INCR, '0);
      queue_command(CMD_ALLOC, '0);
      wait_for_quiet();

      // directed: counting on, pages below 100 reserved
      set_config(16'd100, 1'b1);
      queue_command(CMD_FREE, 16'd99);
      queue_command(CMD_FREE, 16'd100);
      queue_command(CMD_INCR, 16'd100);
      queue_command(CMD_INCR, 16'd100);
      queue_command(CMD_FREE, 16'd100);
      queue_command(CMD_FREE, 16'd100);
      queue_command(CMD_ALLOC, LAST_PAGE);
      queue_command(CMD_ALLOC, '0);
      queue_command(CMD_ALLOC, '0);
      queue_command(CMD_READ, 16'd100);
      queue_command(CMD_INCR, 16'hAAAA);
      queue_command(CMD_INCR, 16'h5555);
      queue_command(CMD_FREE, LAST_PAGE);
      queue_command(CMD_FREE, 16'h5555);
      queue_command(CMD_FREE, '0);
      wait_for_quiet();

      idle_pct = 26;
      set_config(PAGE_BITS'($urandom_range(1, 4095)), 1'b1);
      queue_random_mix(300);
      wait_for_quiet();

      set_config(LAST_PAGE, 1'b0);
      queue_random_mix(150);
      wait_for_quiet();

      idle_pct = 0;
      set_config('0, 1'b1);
      queue_random_mix(250);
      wait_for_quiet();

      idle_pct = 26;
      set_config(PAGE_BITS'($urandom), 1'b1);
      queue_random_mix(200);
      wait_for_quiet();
      repeat (10) @(posedge clock);

      $display("Sent %0d requests, checked %0d results: directed corners with counting",
               sent_total, checked_total);
      $display("off and on, then random mixes over four register settings.");
      if (mismatches == 0 && results_due.size() == 0) begin
         $display("[refcounted_page_allocator_core] OK");
      end else begin
         $display("%0d mismatches, %0d results missing", mismatches, results_due.size());
         $display("[refcounted_page_allocator_core] ERROR");
      end
      $finish;
   end

endmodule
